FILE: sv/shader_token_decoder_defines.svh
// assertion macros for the shader token decoder
`ifndef SHADER_TOKEN_DECODER_DEFINES_SVH
`define SHADER_TOKEN_DECODER_DEFINES_SVH

// immediate implication checked on every edge out of reset
`define STD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define STD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: sv/std_pkg.sv
//------------------------------------------------------------------------------
// std_pkg
// shared types and constants of the shader token decoder
//------------------------------------------------------------------------------
`default_nettype none
package std_pkg;
	localparam int unsigned NUM_INPUT_REGS    = 16;
	localparam int unsigned NUM_CONSTANT_REGS = 96;
	localparam int unsigned MAX_INSTRUCTIONS  = 128;
	localparam int unsigned QDEPTH            = 4;
	localparam int unsigned QAW               = 2;

	localparam logic [1:0] KIND_INSTR  = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REFUSE = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_OPCODE   = 3'd1;
	localparam logic [2:0] ERR_TRUNC    = 3'd2;
	localparam logic [2:0] ERR_TOO_MANY = 3'd3;
	localparam logic [2:0] ERR_SOURCE   = 3'd4;
	localparam logic [2:0] ERR_MODIFIER = 3'd5;
	localparam logic [2:0] ERR_CONST    = 3'd6;
	localparam logic [2:0] ERR_DEST     = 3'd7;

	typedef enum logic [4:0] {
		PH_VERSION = 5'b00001,
		PH_OPCODE  = 5'b00010,
		PH_DEST    = 5'b00100,
		PH_SOURCE  = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	// classified token handed from front to back
	typedef struct packed {
		logic [31:0] token;
		logic        final_token;
	} word_t;

	// one result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [7:0]  slot;
		logic [3:0]  opcode;
		logic [1:0]  dest_file;
		logic [3:0]  dest_index;
		logic [3:0]  write_mask;
		logic [1:0]  source_count;
		logic [23:0] source_a;
		logic [23:0] source_b;
		logic [23:0] source_c;
	} result_t;

	function automatic logic [4:0] token_type(input logic [31:0] t);
		return {t[12:11], t[30:28]};
	endfunction

	// writable register check: {ok, file[1:0], idx[3:0]}
	function automatic logic [6:0] writable(input logic [4:0] ty, input logic [10:0] n);
		logic [6:0] r;
		r = 7'd0;
		if (ty == 5'd0 && n < 11'd12) r = {1'b1, 2'd0, n[3:0]};
		else if (ty == 5'd3 && n == 11'd0) r = {1'b1, 2'd1, 4'd0};
		else if (ty == 5'd4 && n < 11'd3) r = {1'b1, 2'd2, n[3:0]};
		else if (ty == 5'd5 && n < 11'd2) r = {1'b1, 2'd2, 4'd3 + n[3:0]};
		else if (ty == 5'd6 && n < 11'd8) r = {1'b1, 2'd2, 4'd5 + n[3:0]};
		return r;
	endfunction

	function automatic logic [1:0] sources_of(input logic [15:0] op);
		logic [1:0] r;
		case (op)
			16'd1: r = 2'd1;
			16'd2, 16'd3, 16'd5, 16'd8, 16'd9: r = 2'd2;
			16'd4: r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: sv/std_queue.sv
//------------------------------------------------------------------------------
// std_queue
// small register queue between front and back
//------------------------------------------------------------------------------
`default_nettype none
module std_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire std_pkg::word_t  wdata,
	output logic                 full,
	input  wire logic            rd,
	output std_pkg::word_t       rdata,
	output logic                 empty
);
	std_pkg::word_t mem_q [std_pkg::QDEPTH];
	logic [std_pkg::QAW-1:0] wp_q, rp_q;
	logic [std_pkg::QAW:0]   cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == 3'(std_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, do_wr} - {2'b0, do_rd};
		end
	end
endmodule
`default_nettype wire

FILE: sv/std_back.sv
//------------------------------------------------------------------------------
// std_back
// parse state machine and result queue
//------------------------------------------------------------------------------
`default_nettype none
module std_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire std_pkg::word_t  wd,
	input  wire logic            wd_valid,
	output logic                 wd_take,
	output std_pkg::result_t     res,
	output logic                 res_empty,
	input  wire logic            res_pop
);
	// result queue, four deep; a token needs room for two words
	std_pkg::result_t rq_q [4];
	logic [1:0] rwp_q, rrp_q;
	logic [2:0] rcnt_q;

	std_pkg::phase_t phase_q;
	logic [1:0]  pos_q, hcount_q;
	logic [3:0]  hop_q;
	logic [9:0]  hdest_q;
	logic [23:0] hsrc_q [3];
	logic [2:0]  perr_q;
	logic [7:0]  icount_q;

	std_pkg::phase_t phase_n;
	logic [1:0]  pos_n, hcount_n;
	logic [3:0]  hop_n;
	logic [9:0]  hdest_n;
	logic [23:0] hsrc_n [3];
	logic [2:0]  perr_n;
	logic [7:0]  icount_n;
	std_pkg::result_t r0, r1;
	logic [1:0] nres;

	logic [31:0] t;
	logic        fin;
	logic [15:0] op;
	logic [1:0]  ns;
	logic [6:0]  wr_d;
	logic [4:0]  ty;
	logic [10:0] n;
	logic [2:0]  serr;
	logic [23:0] sval;
	logic [2:0]  sfile;
	logic        srel, sneg;
	logic [6:0]  wr_s;
	logic [3:0]  mask;
	logic [1:0]  npos;
	logic        do_pop;

	assign wd_take = wd_valid && (rcnt_q <= 3'd2);
	assign do_pop  = res_pop && !res_empty;
	assign res_empty = (rcnt_q == 3'd0);
	assign res = rq_q[rrp_q];

	assign t   = wd.token;
	assign fin = wd.final_token;
	assign op  = t[15:0];
	assign ns  = std_pkg::sources_of(op);
	assign ty  = std_pkg::token_type(t);
	assign n   = t[10:0];
	assign wr_d = std_pkg::writable(ty, n);
	assign wr_s = wr_d;
	assign mask = (t[19:16] == 4'd0) ? 4'd15 : t[19:16];
	assign npos = pos_q + 2'd1;

	// source operand decode
	always_comb begin
		serr = std_pkg::ERR_NONE;
		sfile = 3'd0;
		srel = 1'b0;
		sneg = 1'b0;
		sval = '0;
		if (ty == 5'd1) begin
			if (n < 11'(std_pkg::NUM_INPUT_REGS)) sfile = 3'd3;
			else serr = std_pkg::ERR_SOURCE;
		end else if (ty == 5'd2) begin
			if (t[13]) begin
				srel = 1'b1;
				sfile = 3'd4;
			end else if (n < 11'(std_pkg::NUM_CONSTANT_REGS)) sfile = 3'd4;
			else serr = std_pkg::ERR_CONST;
		end else if (!wr_s[6]) begin
			serr = std_pkg::ERR_SOURCE;
		end else begin
			sfile = {1'b0, wr_s[5:4]};
		end
		if (serr == std_pkg::ERR_NONE) begin
			if (t[27:24] == 4'd1) sneg = 1'b1;
			else if (t[27:24] != 4'd0) serr = std_pkg::ERR_MODIFIER;
		end
		if (serr == std_pkg::ERR_NONE) begin
			sval = {t[23:16], sneg, srel, sfile,
				(ty == 5'd1 || ty == 5'd2) ? n : {7'd0, wr_s[3:0]}};
		end
	end

	function automatic std_pkg::result_t rep(input logic [1:0] k, input logic [2:0] e,
			input logic [7:0] c);
		std_pkg::result_t r;
		r = '0;
		r.kind = k;
		r.error_code = e;
		r.slot = c;
		return r;
	endfunction

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		hcount_n = hcount_q;
		hop_n = hop_q;
		hdest_n = hdest_q;
		hsrc_n = hsrc_q;
		perr_n = perr_q;
		icount_n = icount_q;
		r0 = '0;
		r1 = '0;
		nres = 2'd0;
		case (phase_q)
			std_pkg::PH_VERSION: begin
				icount_n = '0;
				if (fin) begin
					r0 = rep(std_pkg::KIND_ACCEPT, std_pkg::ERR_NONE, 8'd0);
					nres = 2'd1;
				end else phase_n = std_pkg::PH_OPCODE;
			end
			std_pkg::PH_OPCODE: begin
				if (op == 16'hffff) begin
					r0 = rep(std_pkg::KIND_ACCEPT, std_pkg::ERR_NONE, icount_q);
					nres = 2'd1;
					phase_n = fin ? std_pkg::PH_VERSION : std_pkg::PH_SKIP;
				end else if (ns == 2'd0) begin
					r0 = rep(std_pkg::KIND_REFUSE, std_pkg::ERR_OPCODE, icount_q);
					nres = 2'd1;
					phase_n = fin ? std_pkg::PH_VERSION : std_pkg::PH_SKIP;
				end else if (fin) begin
					r0 = rep(std_pkg::KIND_REFUSE, std_pkg::ERR_TRUNC, icount_q);
					nres = 2'd1;
					phase_n = std_pkg::PH_VERSION;
				end else begin
					hop_n = op[3:0];
					hcount_n = ns;
					hsrc_n[0] = '0;
					hsrc_n[1] = '0;
					hsrc_n[2] = '0;
					perr_n = (icount_q >= 8'(std_pkg::MAX_INSTRUCTIONS)) ?
						std_pkg::ERR_TOO_MANY : std_pkg::ERR_NONE;
					pos_n = '0;
					phase_n = std_pkg::PH_DEST;
				end
			end
			std_pkg::PH_DEST: begin
				if (fin) begin
					r0 = rep(std_pkg::KIND_REFUSE, std_pkg::ERR_TRUNC, icount_q);
					nres = 2'd1;
					phase_n = std_pkg::PH_VERSION;
				end else begin
					hdest_n = wr_d[6] ? {wr_d[5:4], wr_d[3:0], mask} : {2'd3, 4'd0, mask};
					phase_n = std_pkg::PH_SOURCE;
				end
			end
			std_pkg::PH_SOURCE: begin
				if (pos_q != 2'd3) hsrc_n[pos_q] = sval;
				if (perr_q == std_pkg::ERR_NONE && serr != std_pkg::ERR_NONE) perr_n = serr;
				pos_n = npos;
				if (npos < hcount_q) begin
					if (fin) begin
						r0 = rep(std_pkg::KIND_REFUSE, std_pkg::ERR_TRUNC, icount_q);
						nres = 2'd1;
						phase_n = std_pkg::PH_VERSION;
					end
				end else if (perr_n != std_pkg::ERR_NONE) begin
					r0 = rep(std_pkg::KIND_REFUSE, perr_n, icount_q);
					nres = 2'd1;
					phase_n = fin ? std_pkg::PH_VERSION : std_pkg::PH_SKIP;
				end else if (hdest_q[9:8] == 2'd3) begin
					r0 = rep(std_pkg::KIND_REFUSE, std_pkg::ERR_DEST, icount_q);
					nres = 2'd1;
					phase_n = fin ? std_pkg::PH_VERSION : std_pkg::PH_SKIP;
				end else begin
					r0.kind = std_pkg::KIND_INSTR;
					r0.error_code = std_pkg::ERR_NONE;
					r0.slot = icount_q;
					r0.opcode = hop_q;
					r0.dest_file = hdest_q[9:8];
					r0.dest_index = hdest_q[7:4];
					r0.write_mask = hdest_q[3:0];
					r0.source_count = hcount_q;
					r0.source_a = hsrc_n[0];
					r0.source_b = hsrc_n[1];
					r0.source_c = hsrc_n[2];
					icount_n = icount_q + 8'd1;
					if (fin) begin
						r1 = rep(std_pkg::KIND_ACCEPT, std_pkg::ERR_NONE, icount_n);
						nres = 2'd2;
						phase_n = std_pkg::PH_VERSION;
					end else begin
						nres = 2'd1;
						phase_n = std_pkg::PH_OPCODE;
					end
				end
			end
			default: begin
				if (fin) phase_n = std_pkg::PH_VERSION;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wd_take) begin
			if (nres != 2'd0) rq_q[rwp_q] <= r0;
			if (nres == 2'd2) rq_q[rwp_q + 2'd1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q <= '0;
			rrp_q <= '0;
			rcnt_q <= '0;
			phase_q <= std_pkg::PH_VERSION;
			pos_q <= '0;
			hcount_q <= '0;
			hop_q <= '0;
			hdest_q <= '0;
			hsrc_q[0] <= '0;
			hsrc_q[1] <= '0;
			hsrc_q[2] <= '0;
			perr_q <= '0;
			icount_q <= '0;
		end else begin
			if (do_pop) rrp_q <= rrp_q + 2'd1;
			if (wd_take) begin
				rwp_q <= rwp_q + nres;
				phase_q <= phase_n;
				pos_q <= pos_n;
				hcount_q <= hcount_n;
				hop_q <= hop_n;
				hdest_q <= hdest_n;
				hsrc_q <= hsrc_n;
				perr_q <= perr_n;
				icount_q <= icount_n;
			end
			rcnt_q <= rcnt_q + (wd_take ? {1'b0, nres} : 3'd0) - {2'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

FILE: sv/shader_token_decoder.sv
// Shader token decoder.
// Input channel: push/full with token and final_token; one program dword per
// word, final_token set on the program's last dword. The version token is
// skipped, then opcode, destination and source tokens are parsed.
// Result channel: empty/pop with kind, error_code, slot and the decoded
// fields; the oldest result is shown while empty is low.
// Throughput: one token per cycle sustained. A token enters a four-entry
// queue (front), the parser (back) takes one per cycle while its four-entry
// result queue has room for two words.
// Path: a token that completes a group is written into the token queue; the
// parser takes it from there once the result queue has room for two words
// and writes its result into the result queue register.
// Reset clears both queues and returns the parser to expecting a version.
// When the receiver stalls the result queue fills, the parser stops taking
// tokens and the token queue raises full once its four entries are used.
`default_nettype none
module shader_token_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] token,
	input  wire logic        final_token,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [2:0]       error_code,
	output logic [7:0]       slot,
	output logic [3:0]       opcode,
	output logic [1:0]       dest_file,
	output logic [3:0]       dest_index,
	output logic [3:0]       write_mask,
	output logic [1:0]       source_count,
	output logic [23:0]      source_a,
	output logic [23:0]      source_b,
	output logic [23:0]      source_c
);
	std_pkg::word_t   in_w, q_w;
	std_pkg::result_t res;
	logic q_empty, q_take;

	assign in_w.token = token;
	assign in_w.final_token = final_token;

	std_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(push), .wdata(in_w), .full(full),
		.rd(q_take), .rdata(q_w), .empty(q_empty)
	);

	std_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wd(q_w), .wd_valid(!q_empty), .wd_take(q_take),
		.res(res), .res_empty(empty), .res_pop(pop)
	);

	assign kind = res.kind;
	assign error_code = res.error_code;
	assign slot = res.slot;
	assign opcode = res.opcode;
	assign dest_file = res.dest_file;
	assign dest_index = res.dest_index;
	assign write_mask = res.write_mask;
	assign source_count = res.source_count;
	assign source_a = res.source_a;
	assign source_b = res.source_b;
	assign source_c = res.source_c;
endmodule
`default_nettype wire

FILE: sv/std_checker.sv
//------------------------------------------------------------------------------
// std_checker
// port-level checks of the shader token decoder
//------------------------------------------------------------------------------
`default_nettype none
`include "shader_token_decoder_defines.svh"
module std_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [1:0]  kind,
	input wire logic [2:0]  error_code,
	input wire logic [3:0]  write_mask,
	input wire logic [1:0]  source_count
);
	// result held while stalled
	`STD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(kind))
	// instructions carry no error and a full word
	`STD_ASSERT_IMP(a_instr, !empty && kind == std_pkg::KIND_INSTR,
		error_code == std_pkg::ERR_NONE && write_mask != 4'd0 && source_count != 2'd0)
	// accepted reports carry no error, refused ones do
	`STD_ASSERT_IMP(a_refuse, !empty && kind == std_pkg::KIND_REFUSE,
		error_code != std_pkg::ERR_NONE)
	`STD_ASSERT_IMP(a_accept, !empty && kind == std_pkg::KIND_ACCEPT,
		error_code == std_pkg::ERR_NONE && source_count == 2'd0)
endmodule

bind shader_token_decoder std_checker u_std_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .kind(kind),
	.error_code(error_code), .write_mask(write_mask), .source_count(source_count)
);
`default_nettype wire

FILE: verif/tb_shader_token_decoder.sv
//------------------------------------------------------------------------------
// shader token decoder testbench
// Streams vertex shader programs into the decoder: directed programs for each
// opcode, register file, error and ending case, then random programs that are
// mostly well formed with random fields plus broken and noisy ones. Every
// result word is checked field by field against a behavioral predictor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_shader_token_decoder;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] token;
	logic        final_token;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [2:0]  error_code;
	logic [7:0]  slot;
	logic [3:0]  opcode;
	logic [1:0]  dest_file;
	logic [3:0]  dest_index;
	logic [3:0]  write_mask;
	logic [1:0]  source_count;
	logic [23:0] source_a;
	logic [23:0] source_b;
	logic [23:0] source_c;

	shader_token_decoder uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .token(token),
		.final_token(final_token), .empty(empty), .pop(pop), .kind(kind),
		.error_code(error_code), .slot(slot), .opcode(opcode), .dest_file(dest_file),
		.dest_index(dest_index), .write_mask(write_mask), .source_count(source_count),
		.source_a(source_a), .source_b(source_b), .source_c(source_c)
	);

	// opcode values
	localparam logic [15:0] OP_MOV = 16'd1;
	localparam logic [15:0] OP_ADD = 16'd2;
	localparam logic [15:0] OP_SUB = 16'd3;
	localparam logic [15:0] OP_MAD = 16'd4;
	localparam logic [15:0] OP_MUL = 16'd5;
	localparam logic [15:0] OP_DP3 = 16'd8;
	localparam logic [15:0] OP_DP4 = 16'd9;
	localparam logic [15:0] OP_END = 16'hffff;

	// register type codes as split across token bits
	localparam logic [4:0] RT_TEMP   = 5'd0;
	localparam logic [4:0] RT_INPUT  = 5'd1;
	localparam logic [4:0] RT_CONST  = 5'd2;
	localparam logic [4:0] RT_ADDR   = 5'd3;
	localparam logic [4:0] RT_POS    = 5'd4;
	localparam logic [4:0] RT_COLOR  = 5'd5;
	localparam logic [4:0] RT_TEXOUT = 5'd6;

	localparam logic [2:0] SF_TEMP  = 3'd0;
	localparam logic [2:0] SF_ADDR  = 3'd1;
	localparam logic [2:0] SF_OUT   = 3'd2;
	localparam logic [2:0] SF_INPUT = 3'd3;
	localparam logic [2:0] SF_CONST = 3'd4;

	typedef enum logic [2:0] {
		DP_VERSION, DP_OPCODE, DP_DEST, DP_SOURCE, DP_SKIP
	} dec_phase_t;

	// decoder state mirror
	dec_phase_t  dp;
	logic [1:0]  opnd_pos;
	logic [3:0]  cur_op;
	logic [1:0]  cur_nsrc;
	logic [9:0]  cur_dst;
	logic [23:0] cur_src [3];
	logic [2:0]  cur_err;
	logic [7:0]  instr_cnt;

	std_pkg::result_t expected_words [$];
	int      err_count;
	int      words_seen;
	int      tokens_sent;
	int      programs_sent;
	int      idle_cycles;
	bit      rx_hold;
	bit      rx_gaps;
	bit      tx_gaps;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [4:0] type_of(input logic [31:0] t);
		return {t[12:11], t[30:28]};
	endfunction

	// {ok, file, idx}
	function automatic logic [6:0] dest_lookup(input logic [4:0] ty, input logic [10:0] n);
		if (ty == RT_TEMP && n < 12) return {1'b1, 2'd0, n[3:0]};
		if (ty == RT_ADDR && n == 0) return {1'b1, 2'd1, 4'd0};
		if (ty == RT_POS && n < 3) return {1'b1, 2'd2, n[3:0]};
		if (ty == RT_COLOR && n < 2) return {1'b1, 2'd2, 4'(3 + n)};
		if (ty == RT_TEXOUT && n < 8) return {1'b1, 2'd2, 4'(5 + n)};
		return 7'd0;
	endfunction

	function automatic logic [1:0] operand_total(input logic [15:0] op);
		case (op)
			OP_MOV: return 2'd1;
			OP_ADD, OP_SUB, OP_MUL, OP_DP3, OP_DP4: return 2'd2;
			OP_MAD: return 2'd3;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [23:0] operand_decode(input logic [31:0] t, output logic [2:0] e);
		logic [4:0]  ty;
		logic [10:0] n;
		logic [2:0]  f;
		logic [10:0] num;
		logic        rel;
		logic        neg;
		logic [6:0]  w;
		logic [3:0]  md;
		ty = type_of(t);
		n = t[10:0];
		f = SF_TEMP;
		num = '0;
		rel = 1'b0;
		neg = 1'b0;
		e = std_pkg::ERR_NONE;
		if (ty == RT_INPUT) begin
			if (n < std_pkg::NUM_INPUT_REGS) begin f = SF_INPUT; num = n; end
			else e = std_pkg::ERR_SOURCE;
		end else if (ty == RT_CONST) begin
			if (t[13]) begin rel = 1'b1; f = SF_CONST; num = n; end
			else if (n < std_pkg::NUM_CONSTANT_REGS) begin f = SF_CONST; num = n; end
			else e = std_pkg::ERR_CONST;
		end else begin
			w = dest_lookup(ty, n);
			if (!w[6]) e = std_pkg::ERR_SOURCE;
			else begin f = {1'b0, w[5:4]}; num = {7'd0, w[3:0]}; end
		end
		if (e != std_pkg::ERR_NONE) return '0;
		md = t[27:24];
		if (md == 4'd1) neg = 1'b1;
		else if (md != 0) begin e = std_pkg::ERR_MODIFIER; return '0; end
		return {t[23:16], neg, rel, f, num};
	endfunction

	function automatic std_pkg::result_t report_word(input logic [1:0] k, input logic [2:0] e);
		std_pkg::result_t r;
		r = '0;
		r.kind = k;
		r.error_code = e;
		r.slot = instr_cnt;
		return r;
	endfunction

	task automatic close_program(input logic [1:0] k, input logic [2:0] e, input bit fin);
		expected_words.push_back(report_word(k, e));
		dp = fin ? DP_VERSION : DP_SKIP;
	endtask

	task automatic predict_token(input logic [31:0] t, input bit fin);
		logic [6:0]  w;
		logic [2:0]  e;
		logic [23:0] s;
		logic [1:0]  pos;
		std_pkg::result_t r;
		case (dp)
			DP_VERSION: begin
				instr_cnt = 0;
				if (fin) close_program(std_pkg::KIND_ACCEPT, std_pkg::ERR_NONE, 1);
				else dp = DP_OPCODE;
			end
			DP_OPCODE: begin
				if (t[15:0] == OP_END)
					close_program(std_pkg::KIND_ACCEPT, std_pkg::ERR_NONE, fin);
				else if (operand_total(t[15:0]) == 0)
					close_program(std_pkg::KIND_REFUSE, std_pkg::ERR_OPCODE, fin);
				else if (fin) close_program(std_pkg::KIND_REFUSE, std_pkg::ERR_TRUNC, 1);
				else begin
					cur_op = t[3:0];
					cur_nsrc = operand_total(t[15:0]);
					cur_src[0] = '0; cur_src[1] = '0; cur_src[2] = '0;
					cur_err = (instr_cnt >= std_pkg::MAX_INSTRUCTIONS) ?
						std_pkg::ERR_TOO_MANY : std_pkg::ERR_NONE;
					opnd_pos = 0;
					dp = DP_DEST;
				end
			end
			DP_DEST: begin
				if (fin) close_program(std_pkg::KIND_REFUSE, std_pkg::ERR_TRUNC, 1);
				else begin
					w = dest_lookup(type_of(t), t[10:0]);
					if (!w[6]) w = {1'b0, 2'd3, 4'd0};
					cur_dst = {w[5:4], w[3:0], (t[19:16] == 0) ? 4'd15 : t[19:16]};
					dp = DP_SOURCE;
				end
			end
			DP_SOURCE: begin
				pos = opnd_pos;
				s = operand_decode(t, e);
				if (pos < 3) cur_src[pos] = s;
				if (cur_err == std_pkg::ERR_NONE && e != std_pkg::ERR_NONE) cur_err = e;
				opnd_pos = pos + 1;
				if (opnd_pos < cur_nsrc) begin
					if (fin) close_program(std_pkg::KIND_REFUSE, std_pkg::ERR_TRUNC, 1);
				end else if (cur_err != std_pkg::ERR_NONE)
					close_program(std_pkg::KIND_REFUSE, cur_err, fin);
				else if (cur_dst[9:8] == 2'd3)
					close_program(std_pkg::KIND_REFUSE, std_pkg::ERR_DEST, fin);
				else begin
					r = '0;
					r.kind = std_pkg::KIND_INSTR;
					r.slot = instr_cnt;
					r.opcode = cur_op;
					r.dest_file = cur_dst[9:8];
					r.dest_index = cur_dst[7:4];
					r.write_mask = cur_dst[3:0];
					r.source_count = cur_nsrc;
					r.source_a = cur_src[0];
					r.source_b = cur_src[1];
					r.source_c = cur_src[2];
					expected_words.push_back(r);
					instr_cnt = instr_cnt + 1;
					if (fin) close_program(std_pkg::KIND_ACCEPT, std_pkg::ERR_NONE, 1);
					else dp = DP_OPCODE;
				end
			end
			default: if (fin) dp = DP_VERSION;
		endcase
	endtask

	// random gap: mostly zero or short, occasionally long
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send_word(input logic [31:0] t, input bit fin);
		int g;
		if (tx_gaps) begin
			g = gap_len();
			if (g > 0) begin
				push = 1'b0;
				repeat (g) @(negedge clk);
			end
		end
		push = 1'b1;
		token = t;
		final_token = fin;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_token(t, fin);
		tokens_sent++;
		if (fin) programs_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	// token builders
	function automatic logic [31:0] reg_token(input logic [4:0] ty, input logic [10:0] n,
			input logic [7:0] hi, input logic [3:0] md, input bit relbit);
		logic [31:0] t;
		t = $urandom();
		t[30:28] = ty[2:0];
		t[12:11] = ty[4:3];
		t[10:0] = n;
		t[23:16] = hi;
		t[27:24] = md;
		t[13] = relbit;
		return t;
	endfunction

	function automatic logic [31:0] good_source();
		int p;
		logic [3:0] md;
		md = ($urandom_range(3) == 0) ? 4'd1 : 4'd0;
		p = $urandom_range(5);
		case (p)
			0: return reg_token(RT_TEMP, $urandom_range(11), $urandom, md, $urandom);
			1: return reg_token(RT_INPUT, $urandom_range(std_pkg::NUM_INPUT_REGS - 1),
					$urandom, md, $urandom);
			2: return reg_token(RT_CONST, $urandom_range(std_pkg::NUM_CONSTANT_REGS - 1),
					$urandom, md, 1'b0);
			3: return reg_token(RT_CONST, $urandom, $urandom, md, 1'b1);
			4: return reg_token(RT_ADDR, 0, $urandom, md, $urandom);
			default: return reg_token(RT_TEXOUT, $urandom_range(7), $urandom, md, $urandom);
		endcase
	endfunction

	function automatic logic [31:0] good_dest();
		int p;
		logic [31:0] t;
		p = $urandom_range(4);
		case (p)
			0: t = reg_token(RT_TEMP, $urandom_range(11), $urandom, $urandom, $urandom);
			1: t = reg_token(RT_ADDR, 0, $urandom, $urandom, $urandom);
			2: t = reg_token(RT_POS, $urandom_range(2), $urandom, $urandom, $urandom);
			3: t = reg_token(RT_COLOR, $urandom_range(1), $urandom, $urandom, $urandom);
			default: t = reg_token(RT_TEXOUT, $urandom_range(7), $urandom, $urandom, $urandom);
		endcase
		return t;
	endfunction

	function automatic logic [31:0] op_token(input logic [15:0] op);
		logic [31:0] t;
		t = $urandom();
		t[15:0] = op;
		return t;
	endfunction

	function automatic logic [15:0] rand_op();
		logic [15:0] ops [7];
		ops = '{OP_MOV, OP_ADD, OP_SUB, OP_MAD, OP_MUL, OP_DP3, OP_DP4};
		return ops[$urandom_range(6)];
	endfunction

	// one instruction group, last token flagged when fin is set
	task automatic send_group(input logic [15:0] op, input bit fin);
		int n;
		send_word(op_token(op), 0);
		send_word(good_dest(), 0);
		n = operand_total(op);
		for (int i = 0; i < n; i++) send_word(good_source(), fin && i == n - 1);
	endtask

	// sender pauses until every expected word is back
	task automatic wait_drained();
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk) begin
		std_pkg::result_t r;
		std_pkg::result_t x;
		if (arst_n && push && !full || arst_n && pop && !empty) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (arst_n && pop && !empty) begin
			r = '{kind, error_code, slot, opcode, dest_file, dest_index, write_mask,
				source_count, source_a, source_b, source_c};
			words_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, r);
				err_count++;
			end else begin
				x = expected_words.pop_front();
				if (r.kind != x.kind) begin
					$display("%0t: kind exp %0d got %0d", $time, x.kind, r.kind); err_count++; end
				if (r.error_code != x.error_code) begin
					$display("%0t: error_code exp %0d got %0d", $time, x.error_code,
						r.error_code); err_count++; end
				if (r.slot != x.slot) begin
					$display("%0t: slot exp %0d got %0d", $time, x.slot, r.slot); err_count++; end
				if (r.opcode != x.opcode) begin
					$display("%0t: opcode exp %0d got %0d", $time, x.opcode, r.opcode);
					err_count++; end
				if (r.dest_file != x.dest_file) begin
					$display("%0t: dest_file exp %0d got %0d", $time, x.dest_file, r.dest_file);
					err_count++; end
				if (r.dest_index != x.dest_index) begin
					$display("%0t: dest_index exp %0d got %0d", $time, x.dest_index,
						r.dest_index); err_count++; end
				if (r.write_mask != x.write_mask) begin
					$display("%0t: write_mask exp %h got %h", $time, x.write_mask, r.write_mask);
					err_count++; end
				if (r.source_count != x.source_count) begin
					$display("%0t: source_count exp %0d got %0d", $time, x.source_count,
						r.source_count); err_count++; end
				if (r.source_a != x.source_a) begin
					$display("%0t: source_a exp %h got %h", $time, x.source_a, r.source_a);
					err_count++; end
				if (r.source_b != x.source_b) begin
					$display("%0t: source_b exp %h got %h", $time, x.source_b, r.source_b);
					err_count++; end
				if (r.source_c != x.source_c) begin
					$display("%0t: source_c exp %h got %h", $time, x.source_c, r.source_c);
					err_count++; end
			end
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no progress", $time);
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold when asked
	always @(negedge clk) begin
		int g;
		if (!arst_n) pop <= 1'b0;
		else if (rx_hold) pop <= 1'b0;
		else if (rx_gaps && $urandom_range(3) == 0) begin
			pop <= 1'b0;
			g = gap_len();
			if (g > 1) repeat (g - 1) @(negedge clk);
		end else pop <= 1'b1;
	end

	task automatic test_each_opcode();
		logic [15:0] ops [7];
		ops = '{OP_MOV, OP_ADD, OP_SUB, OP_MAD, OP_MUL, OP_DP3, OP_DP4};
		send_word(32'hfffe0101, 0);
		foreach (ops[i]) send_group(ops[i], 0);
		// output destinations, input, constant, output and address sources, extreme numbers and masks
		send_word(op_token(OP_MAD), 0);
		send_word(reg_token(RT_TEXOUT, 7, 8'h00, 4'd0, 1'b0), 0);
		send_word(reg_token(RT_INPUT, std_pkg::NUM_INPUT_REGS - 1, 8'hff, 4'd1, 1'b1), 0);
		send_word(reg_token(RT_CONST, std_pkg::NUM_CONSTANT_REGS - 1, 8'h00, 4'd0, 1'b0), 0);
		send_word(reg_token(RT_CONST, 11'h7ff, 8'ha5, 4'd1, 1'b1), 0);
		send_word(op_token(OP_ADD), 0);
		send_word(reg_token(RT_COLOR, 1, 8'hf0, 4'd0, 1'b0), 0);
		send_word(reg_token(RT_POS, 2, 8'h1b, 4'd0, 1'b0), 0);
		send_word(reg_token(RT_ADDR, 0, 8'he4, 4'd1, 1'b0), 0);
		send_word(32'hffffffff, 0);
		send_word(32'h0, 1);
	endtask

	task automatic test_errors();
		// version only
		send_word(32'h0, 1);
		// bad opcode, upper opcode bits ignored
		send_word(32'h0, 0); send_word(32'hffff0007, 1);
		send_word(32'h0, 0); send_word(32'h12340000, 0); send_word(32'h0, 1);
		// truncated on opcode, destination and first source
		send_word(32'h0, 0); send_word(op_token(OP_MOV), 1);
		send_word(32'h0, 0); send_word(op_token(OP_MOV), 0); send_word(good_dest(), 1);
		send_word(32'h0, 0); send_word(op_token(OP_MAD), 0); send_word(good_dest(), 0);
		send_word(reg_token(RT_INPUT, 31, 0, 4'd3, 0), 1);
		// bad source, bad modifier, constant range, bad destination, ordering
		send_word(32'h0, 0); send_word(op_token(OP_ADD), 0);
		send_word(reg_token(RT_POS, 3, 0, 0, 0), 0);
		send_word(reg_token(RT_INPUT, std_pkg::NUM_INPUT_REGS, 0, 0, 0), 0);
		send_word(reg_token(RT_CONST, std_pkg::NUM_CONSTANT_REGS, 0, 0, 0), 1);
		send_word(32'h0, 0); send_word(op_token(OP_ADD), 0); send_word(good_dest(), 0);
		send_word(reg_token(RT_TEMP, 0, 0, 4'd2, 0), 0);
		send_word(reg_token(RT_CONST, std_pkg::NUM_CONSTANT_REGS, 0, 0, 0), 0);
		send_word(32'hffffffff, 0); send_word(32'h0, 1);
		send_word(32'h0, 0); send_word(op_token(OP_MOV), 0);
		send_word(reg_token(5'd31, 0, 0, 0, 0), 0);
		send_word(reg_token(RT_CONST, std_pkg::NUM_CONSTANT_REGS, 0, 0, 0), 1);
		send_word(32'h0, 0); send_word(op_token(OP_MOV), 0);
		send_word(reg_token(RT_TEMP, 12, 0, 0, 0), 0); send_word(good_source(), 1);
	endtask

	task automatic test_too_many();
		send_word(32'h0, 0);
		repeat (std_pkg::MAX_INSTRUCTIONS) send_group(OP_MOV, 0);
		send_group(OP_MOV, 1);
		send_word(32'h0, 0);
		repeat (std_pkg::MAX_INSTRUCTIONS) send_group(OP_MOV, 0);
		send_word(op_token(OP_END), 1);
	endtask

	task automatic test_random_programs(input int budget);
		int n;
		int p;
		while (tokens_sent < budget) begin
			send_word($urandom, 0);
			n = $urandom_range(6);
			p = $urandom_range(9);
			for (int i = 0; i < n; i++) send_group(rand_op(), 0);
			if (p < 4) send_group(rand_op(), 1);
			else if (p < 6) send_word(op_token(OP_END), $urandom_range(1));
			else if (p < 8) begin
				// follow an opcode with random tokens, then finish the stream
				send_word(op_token(rand_op()), 0);
				send_word($urandom_range(1) ? good_dest() : $urandom, 0);
				send_word($urandom, 0);
				repeat ($urandom_range(3)) send_word($urandom, 0);
				send_word($urandom, 1);
			end else begin
				repeat ($urandom_range(6)) send_word($urandom, 0);
				send_word($urandom, 1);
			end
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1;
				repeat (300) @(negedge clk);
				rx_hold = 0;
			end
			begin
				send_word(32'h0, 0);
				repeat (20) send_group(rand_op(), 0);
				send_group(OP_MOV, 1);
			end
		join
		wait_drained();
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		token = '0;
		final_token = 1'b0;
		err_count = 0;
		words_seen = 0;
		tokens_sent = 0;
		programs_sent = 0;
		idle_cycles = 0;
		rx_hold = 0;
		rx_gaps = 0;
		tx_gaps = 0;
		dp = DP_VERSION;
		opnd_pos = 0;
		cur_op = 0;
		cur_nsrc = 0;
		cur_dst = 0;
		cur_src[0] = 0; cur_src[1] = 0; cur_src[2] = 0;
		cur_err = 0;
		instr_cnt = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_each_opcode();
		test_errors();
		wait_drained();
		rx_gaps = 1;
		tx_gaps = 1;
		test_too_many();
		test_backpressure();
		test_random_programs(1400);
		rx_gaps = 0;
		tx_gaps = 0;
		test_random_programs(1700);

		waited = 0;
		while (expected_words.size() != 0 && waited < 50000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);
		$display("run covered %0d tokens in %0d programs, %0d result words checked",
			tokens_sent, programs_sent, words_seen);
		if (err_count == 0 && expected_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d words outstanding", err_count, expected_words.size());
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/std_pkg.sv
sv/std_queue.sv
sv/std_back.sv
sv/shader_token_decoder.sv
sv/std_checker.sv
verif/tb_shader_token_decoder.sv
